/* src/ipct_pkg.sv */
// Shared types, status codes and helpers for the IP packet count table.
package ipct_pkg;

  localparam int TableDepthDefault = 256;

  localparam logic [2:0] ST_COUNTED  = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_HIT      = 3'd3;
  localparam logic [2:0] ST_MISS     = 3'd4;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] count;
  } entry_t;

  typedef struct packed {
    logic incr;
    logic insert;
  } cell_cmd_t;

  function automatic logic [31:0] inc_sat(input logic [31:0] value);
    inc_sat = (value == COUNT_MAX) ? COUNT_MAX : value + 32'd1;
  endfunction

endpackage

/* src/ipct_cell.sv */
// One table slot: holds a key and count, compares, and shifts up from its left neighbor.
module ipct_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmp,
  input  ipct_pkg::cell_cmd_t cmd,
  input  logic [31:0]        ip,
  input  ipct_pkg::entry_t   left_entry,
  input  logic               left_lt,
  output ipct_pkg::entry_t   entry,
  output logic               lt,
  output logic               hit,
  output logic [31:0]        hit_count
);

  logic [31:0] key;
  logic [31:0] count;
  logic        valid;
  logic        match;
  logic        below;

  assign match = valid && (key == ip);
  assign below = valid && (key < ip);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      lt    <= 1'b0;
      hit   <= 1'b0;
    end else if (cmp) begin
      lt        <= below;
      hit       <= match;
      hit_count <= match ? count : 32'd0;
    end else if (cmd.incr && hit) begin
      count <= ipct_pkg::inc_sat(count);
    end else if (cmd.insert && !lt) begin
      if (left_lt) begin
        key   <= ip;
        count <= 32'd1;
        valid <= 1'b1;
      end else begin
        key   <= left_entry.key;
        count <= left_entry.count;
        valid <= left_entry.valid;
      end
    end
  end

  assign entry.valid = valid;
  assign entry.key   = key;
  assign entry.count = count;

endmodule

/* src/ip_packet_count_table_core.sv */
// Top level of the IP packet count table: a sorted row of key/count cells.
//
// Each transfer runs a compare phase (busy), in which every cell compares its key
// with the address, then an update phase (upd), in which the row updates (a count
// increment in the matching cell, or a shift by one slot for an insert) while the
// result is formed; a new transfer is taken as the update runs. The result appears
// on status and packet_count for one cycle with done high, behind the busy, upd
// and done registers; the receiver cannot stall it. Slots carry valid bits cleared
// by reset, so no clearing pass is needed and the block is ready right after reset.
module ip_packet_count_table_core #(
  parameter int TABLE_DEPTH = ipct_pkg::TableDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [31:0] source_ip,
  output logic        done,
  output logic [2:0]  status,
  output logic [31:0] packet_count
);

  logic                upd;
  logic                req_q;
  logic [31:0]         ip_q;
  logic                accept;
  logic                found;
  logic                full;
  logic [31:0]         found_count;
  logic [2:0]          status_next;
  logic [31:0]         count_next;
  ipct_pkg::cell_cmd_t cmd;

  ipct_pkg::entry_t        entries [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]  lts;
  logic [TABLE_DEPTH-1:0]  hits;
  logic [31:0]             hit_counts [TABLE_DEPTH];

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      upd  <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= accept;
      upd  <= busy;
      done <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req_type;
      ip_q  <= source_ip;
    end
    if (upd) begin
      status       <= status_next;
      packet_count <= count_next;
    end
  end

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_head
        ipct_cell u_cell (
          .clk        (clk),
          .rst        (rst),
          .cmp        (busy),
          .cmd        (cmd),
          .ip         (ip_q),
          .left_entry ('0),
          .left_lt    (1'b1),
          .entry      (entries[g]),
          .lt         (lts[g]),
          .hit        (hits[g]),
          .hit_count  (hit_counts[g])
        );
      end else begin : g_body
        ipct_cell u_cell (
          .clk        (clk),
          .rst        (rst),
          .cmp        (busy),
          .cmd        (cmd),
          .ip         (ip_q),
          .left_entry (entries[g-1]),
          .left_lt    (lts[g-1]),
          .entry      (entries[g]),
          .lt         (lts[g]),
          .hit        (hits[g]),
          .hit_count  (hit_counts[g])
        );
      end
    end
  endgenerate

  always_comb begin
    found_count = 32'd0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      found_count = found_count | hit_counts[i];
    end
  end

  assign found = |hits;
  assign full  = entries[TABLE_DEPTH-1].valid;

  assign cmd.incr   = upd && !req_q && found;
  assign cmd.insert = upd && !req_q && !found && !full;

  always_comb begin
    if (req_q) begin
      status_next = found ? ipct_pkg::ST_HIT : ipct_pkg::ST_MISS;
      count_next  = found ? found_count : 32'd0;
    end else if (found) begin
      status_next = ipct_pkg::ST_COUNTED;
      count_next  = ipct_pkg::inc_sat(found_count);
    end else if (full) begin
      status_next = ipct_pkg::ST_FULL;
      count_next  = 32'd0;
    end else begin
      status_next = ipct_pkg::ST_INSERTED;
      count_next  = 32'd1;
    end
  end

`ifndef SYNTHESIS
  a_phase_excl: assert property (@(posedge clk) disable iff (rst) !(busy && upd))
    else $error("compare and update phases overlap");
  a_busy_to_upd: assert property (@(posedge clk) disable iff (rst) busy |=> upd && !busy)
    else $error("compare phase not followed by update");
  a_one_hit: assert property (@(posedge clk) disable iff (rst) upd |-> $onehot0(hits))
    else $error("more than one slot matched");
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
      done && (status == ipct_pkg::ST_FULL || status == ipct_pkg::ST_MISS)
      |-> packet_count == 32'd0)
    else $error("nonzero count on drop or miss");
`endif

endmodule

/* verif/tb_ip_packet_count_table_core.sv */
// Self-checking testbench for the sorted IP packet count table core.
`timescale 1ns / 100ps

module tb_ip_packet_count_table_core;

  localparam int TABLE_DEPTH = 256;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic REQ_COUNT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] count;
  } table_reply_t;

  // Sorted key/count table kept alongside the DUT; queues the replies it owes.
  class packet_table_model;
    logic [31:0]  keys [TABLE_DEPTH];
    logic [31:0]  counts [TABLE_DEPTH];
    int unsigned  n_entries;
    int unsigned  n_errors;
    table_reply_t replies_due [$];

    function new();
      n_entries = 0;
      n_errors = 0;
    endfunction

    function int unsigned lower_bound(logic [31:0] ip);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo = 0;
      hi = n_entries;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (keys[mid] < ip) lo = mid + 1;
        else hi = mid;
      end
      return lo;
    endfunction

    function void note_request(logic lookup, logic [31:0] ip);
      int unsigned  pos;
      int unsigned  i;
      bit           hit;
      table_reply_t r;
      pos = lower_bound(ip);
      hit = (pos < n_entries) && (keys[pos] == ip);
      r.count = '0;
      if (lookup == REQ_LOOKUP) begin
        r.status = hit ? ipct_pkg::ST_HIT : ipct_pkg::ST_MISS;
        if (hit) r.count = counts[pos];
      end else if (hit) begin
        if (counts[pos] != ipct_pkg::COUNT_MAX) counts[pos] = counts[pos] + 32'd1;
        r.status = ipct_pkg::ST_COUNTED;
        r.count = counts[pos];
      end else if (n_entries >= TABLE_DEPTH) begin
        r.status = ipct_pkg::ST_FULL;
      end else begin
        for (i = n_entries; i > pos; i--) begin
          keys[i] = keys[i-1];
          counts[i] = counts[i-1];
        end
        keys[pos] = ip;
        counts[pos] = 32'd1;
        n_entries++;
        r.status = ipct_pkg::ST_INSERTED;
        r.count = 32'd1;
      end
      replies_due.push_back(r);
    endfunction

    function void check_result(logic [2:0] st, logic [31:0] cnt);
      table_reply_t r;
      if (replies_due.size() == 0) begin
        $display("%0t: result with none expected: status %0d count %0d", $time, st, cnt);
        n_errors++;
        return;
      end
      r = replies_due.pop_front();
      if (st !== r.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d", $time, r.status, st);
        n_errors++;
      end
      if (cnt !== r.count) begin
        $display("%0t: packet_count mismatch: expected %0d actual %0d", $time, r.count, cnt);
        n_errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        req_type;
  logic [31:0] source_ip;
  logic        done;
  logic [2:0]  status;
  logic [31:0] packet_count;

  packet_table_model table_model;
  int unsigned       cycles = 0;

  ip_packet_count_table_core #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .source_ip(source_ip),
    .done(done),
    .status(status),
    .packet_count(packet_count)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) table_model.check_result(status, packet_count);
  end

  task automatic send_request(input logic lookup, input logic [31:0] ip);
    start <= 1'b1;
    req_type <= lookup;
    source_ip <= ip;
    do @(posedge clk); while (busy);
    table_model.note_request(lookup, ip);
  endtask

  task automatic pause_sender(input int unsigned pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] stored_key();
    if (table_model.n_entries == 0) return $urandom();
    return table_model.keys[$urandom_range(0, table_model.n_entries - 1)];
  endfunction

  // Mostly keys already in the table or next to one, plus extremes and noise.
  function automatic logic [31:0] mixed_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return stored_key();
    if (r < 52) return stored_key() + 32'd1;
    if (r < 60) return stored_key() - 32'd1;
    if (r < 70) begin
      case ($urandom_range(0, 3))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end
    return $urandom();
  endfunction

  function automatic int unsigned pick_idle_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 15;
      default: return 50;
    endcase
  endfunction

  function automatic logic pick_req();
    return ($urandom_range(0, 9) < 3) ? REQ_LOOKUP : REQ_COUNT;
  endfunction

  initial begin
    logic        dir_req [20];
    logic [31:0] dir_ip [20];
    int unsigned idle_pct;
    int          i;

    dir_req = '{REQ_LOOKUP, REQ_LOOKUP, REQ_COUNT, REQ_COUNT, REQ_COUNT,
                REQ_COUNT, REQ_COUNT, REQ_COUNT, REQ_COUNT, REQ_COUNT,
                REQ_LOOKUP, REQ_LOOKUP, REQ_LOOKUP, REQ_LOOKUP, REQ_LOOKUP,
                REQ_COUNT, REQ_LOOKUP, REQ_COUNT, REQ_COUNT, REQ_LOOKUP};
    dir_ip = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
               32'h0000_0000, 32'h8000_0001, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
               32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0002, 32'h0000_0000, 32'hFFFF_FFFE,
               32'h7FFF_FFFF, 32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA};

    table_model = new();
    rst <= 1'b1;
    start <= 1'b0;
    req_type <= REQ_COUNT;
    source_ip <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty table, unsigned ordering across the sign bit, extremes, hits and misses
    for (i = 0; i < 20; i++) begin
      pause_sender(20);
      send_request(dir_req[i], dir_ip[i]);
    end

    idle_pct = 0;
    for (i = 0; i < 450; i++) begin
      if (i % 100 == 0) idle_pct = pick_idle_pct();
      pause_sender(idle_pct);
      send_request(pick_req(), mixed_key());
    end

    // fill the table with fresh addresses
    while (table_model.n_entries < TABLE_DEPTH) begin
      pause_sender(15);
      send_request(REQ_COUNT, $urandom());
    end

    // full table: drops, counts, hits and misses; no idling at the end
    for (i = 0; i < 780; i++) begin
      if (i % 100 == 0) idle_pct = pick_idle_pct();
      if (i >= 580) idle_pct = 0;
      pause_sender(idle_pct);
      send_request(pick_req(), mixed_key());
    end
    start <= 1'b0;

    while (table_model.replies_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (table_model.n_errors == 0 && table_model.replies_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
